// ===== rtl/kruskal_mst_split_cost_core_macros.svh =====
// Assertion macros shared by the checker file.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef KRUSKAL_MST_SPLIT_COST_CORE_MACROS_SVH
`define KRUSKAL_MST_SPLIT_COST_CORE_MACROS_SVH

// same-cycle implication
`define KMSC_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kmsc check failed");

// next-cycle implication
`define KMSC_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kmsc check failed");

`endif

// ===== rtl/kmsc_pkg.sv =====
// Package for the Kruskal split-cost core: field widths, defaults, limits.
// No dependencies.
package kmsc_pkg;
  localparam int NODE_IN_W     = 10;
  localparam int COST_IN_W     = 16;
  localparam int SUM_W         = 26;
  localparam int CNT_OUT_W     = 10;
  localparam int MAX_NODES_DEF = 1024;
  localparam int MAX_EDGES_DEF = 4096;
  localparam int COST_BITS_DEF = 16;
  localparam logic [SUM_W-1:0]     SUM_MAX = {SUM_W{1'b1}};
  localparam logic [CNT_OUT_W-1:0] CNT_MAX = {CNT_OUT_W{1'b1}};
endpackage

// ===== rtl/kmsc_if.sv =====
// Handshake channels of the Kruskal split-cost core.
// Depends on kmsc_pkg.
interface kmsc_in_if import kmsc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [NODE_IN_W-1:0] node_a;
  logic [NODE_IN_W-1:0] node_b;
  logic [COST_IN_W-1:0] edge_cost;
  logic                 last_edge;
  modport source (output valid, node_a, node_b, edge_cost, last_edge, input ready);
  modport sink   (input valid, node_a, node_b, edge_cost, last_edge, output ready);
endinterface

interface kmsc_out_if import kmsc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [SUM_W-1:0]     split_cost;
  logic [SUM_W-1:0]     tree_cost;
  logic [COST_IN_W-1:0] largest_edge;
  logic [CNT_OUT_W-1:0] edges_used;
  modport source (output valid, split_cost, tree_cost, largest_edge, edges_used,
                  input ready);
  modport sink   (input valid, split_cost, tree_cost, largest_edge, edges_used,
                  output ready);
endinterface

// ===== rtl/kmsc_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module kmsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end
endmodule

// ===== rtl/kruskal_mst_split_cost_core.sv =====
// channel | dir | payload                                           | handshake
// in_ch   | in  | node_a, node_b, edge_cost, last_edge              | valid/ready
// out_ch  | out | split_cost, tree_cost, largest_edge, edges_used   | valid/ready
// Loading an edge: accept, reduce node_a and then node_b modulo MAX_NODES by repeated
// subtraction, order the endpoints into a key, then a sorted insert into the edge RAM
// that shifts larger keys up and writes the new key (no write when the store is full).
// Job on last_edge: clear the parent RAM, then per edge read its key, run the find
// and compress walks on both endpoint paths and join the roots if they differ, then
// load the result, held while the previous one is not taken.
// Synchronous active-low reset; RAM contents are not reset. in_ch.ready is high only
// when idle; a finished result waits in the output register while loading goes on.
// Kruskal split-cost top level. Depends on kmsc_pkg, kmsc_if, kmsc_ram.
module kruskal_mst_split_cost_core import kmsc_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF,
  parameter int MAX_EDGES = MAX_EDGES_DEF,
  parameter int COST_BITS = COST_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  kmsc_in_if.sink  in_ch,
  kmsc_out_if.source out_ch
);
  localparam int NW    = $clog2(MAX_NODES);
  localparam int PW    = NW + 1;
  localparam int EAW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW   = $clog2(MAX_EDGES + 1);
  localparam int CEW   = (COST_BITS < COST_IN_W) ? COST_BITS : COST_IN_W;
  localparam int KEY_W = CEW + 2 * NODE_IN_W;
  localparam logic [16:0]    MN17    = 17'(MAX_NODES);
  localparam logic [ECW-1:0] EMAX    = ECW'(MAX_EDGES);
  localparam logic [NW-1:0]  NLAST   = NW'(MAX_NODES - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MODA  = 4'd1;
  localparam logic [3:0] S_MODB  = 4'd2;
  localparam logic [3:0] S_ORDER = 4'd3;
  localparam logic [3:0] S_INS   = 4'd4;
  localparam logic [3:0] S_INSC  = 4'd5;
  localparam logic [3:0] S_LDONE = 4'd6;
  localparam logic [3:0] S_CLR   = 4'd7;
  localparam logic [3:0] S_EDGE  = 4'd8;
  localparam logic [3:0] S_EKEY  = 4'd9;
  localparam logic [3:0] S_F1    = 4'd10;
  localparam logic [3:0] S_F2    = 4'd11;
  localparam logic [3:0] S_C1    = 4'd12;
  localparam logic [3:0] S_C2    = 4'd13;
  localparam logic [3:0] S_JOIN  = 4'd14;
  localparam logic [3:0] S_FIN   = 4'd15;

  logic [3:0]           st_r, st_nxt;
  logic [NODE_IN_W-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [CEW-1:0]       c_r, c_nxt;
  logic                 last_r, last_nxt;
  logic [KEY_W-1:0]     key_r, key_nxt;
  logic [ECW-1:0]       cnt_r, cnt_nxt, j_r, j_nxt, i_r, i_nxt;
  logic [NW-1:0]        p_r, p_nxt, x_r, x_nxt, start_r, start_nxt;
  logic [NW-1:0]        root_r, root_nxt, ra_r, ra_nxt, hi_r, hi_nxt;
  logic                 ph_r, ph_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [CEW-1:0]       max_r, max_nxt;
  logic [CNT_OUT_W-1:0] acc_r, acc_nxt;
  logic                 ov_r, ov_nxt;
  logic [SUM_W-1:0]     osplit_r, osplit_nxt, otree_r, otree_nxt;
  logic [COST_IN_W-1:0] olarge_r, olarge_nxt;
  logic [CNT_OUT_W-1:0] oused_r, oused_nxt;

  logic             e_we;
  logic [EAW-1:0]   e_waddr, e_raddr;
  logic [KEY_W-1:0] e_wdata, e_rdata;
  logic             p_we;
  logic [NW-1:0]    p_waddr, p_raddr;
  logic [PW-1:0]    p_wdata, p_rdata;

  logic [ECW-1:0]       jm1;
  logic [16:0]          lo_ext, hi_ext;
  logic [NODE_IN_W-1:0] lo_k, hi_k;
  logic [SUM_W:0]       sum_add;

  assign jm1     = j_r - ECW'(1);
  assign lo_k    = (a_r < b_r) ? a_r : b_r;
  assign hi_k    = (a_r < b_r) ? b_r : a_r;
  assign lo_ext  = {7'd0, e_rdata[2*NODE_IN_W-1:NODE_IN_W]};
  assign hi_ext  = {7'd0, e_rdata[NODE_IN_W-1:0]};
  assign sum_add = {1'b0, sum_r} + (SUM_W+1)'(c_r);

  kmsc_ram #(.WIDTH(KEY_W), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata_r(e_rdata)
  );

  kmsc_ram #(.WIDTH(PW), .DEPTH(MAX_NODES)) u_parent_ram (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata_r(p_rdata)
  );

  always_comb begin
    st_nxt = st_r;  a_nxt = a_r;  b_nxt = b_r;  c_nxt = c_r;  last_nxt = last_r;
    key_nxt = key_r;  cnt_nxt = cnt_r;  j_nxt = j_r;  i_nxt = i_r;  p_nxt = p_r;
    x_nxt = x_r;  start_nxt = start_r;  root_nxt = root_r;  ra_nxt = ra_r;
    hi_nxt = hi_r;  ph_nxt = ph_r;  sum_nxt = sum_r;  max_nxt = max_r;
    acc_nxt = acc_r;
    ov_nxt = ov_r & ~out_ch.ready;
    osplit_nxt = osplit_r;  otree_nxt = otree_r;
    olarge_nxt = olarge_r;  oused_nxt = oused_r;
    e_we = 1'b0;  e_waddr = j_r[EAW-1:0];  e_wdata = key_r;  e_raddr = jm1[EAW-1:0];
    p_we = 1'b0;  p_waddr = x_r;  p_wdata = {1'b0, root_r};  p_raddr = x_r;
    case (st_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          a_nxt    = in_ch.node_a;
          b_nxt    = in_ch.node_b;
          c_nxt    = in_ch.edge_cost[CEW-1:0];
          last_nxt = in_ch.last_edge;
          st_nxt   = S_MODA;
        end
      end
      S_MODA: begin
        if ({7'd0, a_r} >= MN17) a_nxt = a_r - MN17[NODE_IN_W-1:0];
        else st_nxt = S_MODB;
      end
      S_MODB: begin
        if ({7'd0, b_r} >= MN17) b_nxt = b_r - MN17[NODE_IN_W-1:0];
        else st_nxt = S_ORDER;
      end
      S_ORDER: begin
        key_nxt = {c_r, lo_k, hi_k};
        j_nxt   = cnt_r;
        st_nxt  = (cnt_r < EMAX) ? S_INS : S_LDONE;
      end
      S_INS: begin
        if (j_r == '0) begin
          e_we    = 1'b1;
          cnt_nxt = cnt_r + ECW'(1);
          st_nxt  = S_LDONE;
        end else begin
          st_nxt = S_INSC;
        end
      end
      S_INSC: begin
        e_we = 1'b1;
        if (e_rdata > key_r) begin
          e_wdata = e_rdata;
          j_nxt   = jm1;
          st_nxt  = S_INS;
        end else begin
          cnt_nxt = cnt_r + ECW'(1);
          st_nxt  = S_LDONE;
        end
      end
      S_LDONE: begin
        p_nxt  = '0;
        st_nxt = last_r ? S_CLR : S_IDLE;
      end
      S_CLR: begin
        p_we    = 1'b1;
        p_waddr = p_r;
        p_wdata = {1'b1, {NW{1'b0}}};
        p_nxt   = p_r + NW'(1);
        if (p_r == NLAST) begin
          i_nxt   = '0;
          sum_nxt = '0;
          max_nxt = '0;
          acc_nxt = '0;
          st_nxt  = S_EDGE;
        end
      end
      S_EDGE: begin
        e_raddr = i_r[EAW-1:0];
        st_nxt  = (i_r == cnt_r) ? S_FIN : S_EKEY;
      end
      S_EKEY: begin
        c_nxt     = e_rdata[KEY_W-1:2*NODE_IN_W];
        x_nxt     = lo_ext[NW-1:0];
        start_nxt = lo_ext[NW-1:0];
        hi_nxt    = hi_ext[NW-1:0];
        ph_nxt    = 1'b0;
        st_nxt    = S_F1;
      end
      S_F1: st_nxt = S_F2;
      S_F2: begin
        if (p_rdata[NW]) begin
          root_nxt = x_r;
          x_nxt    = start_r;
          st_nxt   = S_C1;
        end else begin
          x_nxt  = p_rdata[NW-1:0];
          st_nxt = S_F1;
        end
      end
      S_C1: st_nxt = S_C2;
      S_C2: begin
        if (p_rdata[NW]) begin
          if (!ph_r) begin
            ra_nxt    = root_r;
            ph_nxt    = 1'b1;
            x_nxt     = hi_r;
            start_nxt = hi_r;
            st_nxt    = S_F1;
          end else begin
            st_nxt = S_JOIN;
          end
        end else begin
          p_we   = 1'b1;
          x_nxt  = p_rdata[NW-1:0];
          st_nxt = S_C1;
        end
      end
      S_JOIN: begin
        if (ra_r != root_r) begin
          p_we    = 1'b1;
          p_waddr = root_r;
          p_wdata = {1'b0, ra_r};
          sum_nxt = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
          if (c_r > max_r) max_nxt = c_r;
          if (acc_r != CNT_MAX) acc_nxt = acc_r + CNT_OUT_W'(1);
        end
        i_nxt  = i_r + ECW'(1);
        st_nxt = S_EDGE;
      end
      S_FIN: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt     = 1'b1;
          osplit_nxt = sum_r - SUM_W'(max_r);
          otree_nxt  = sum_r;
          olarge_nxt = COST_IN_W'(max_r);
          oused_nxt  = acc_r;
          cnt_nxt    = '0;
          st_nxt     = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      cnt_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      ov_r  <= ov_nxt;
    end
    a_r <= a_nxt;  b_r <= b_nxt;  c_r <= c_nxt;  last_r <= last_nxt;
    key_r <= key_nxt;  j_r <= j_nxt;  i_r <= i_nxt;  p_r <= p_nxt;
    x_r <= x_nxt;  start_r <= start_nxt;  root_r <= root_nxt;  ra_r <= ra_nxt;
    hi_r <= hi_nxt;  ph_r <= ph_nxt;  sum_r <= sum_nxt;  max_r <= max_nxt;
    acc_r <= acc_nxt;  osplit_r <= osplit_nxt;  otree_r <= otree_nxt;
    olarge_r <= olarge_nxt;  oused_r <= oused_nxt;
  end

  assign in_ch.ready         = (st_r == S_IDLE);
  assign out_ch.valid        = ov_r;
  assign out_ch.split_cost   = osplit_r;
  assign out_ch.tree_cost    = otree_r;
  assign out_ch.largest_edge = olarge_r;
  assign out_ch.edges_used   = oused_r;
endmodule

// ===== rtl/kmsc_checker.sv =====
// Port-level checks for the Kruskal split-cost core, bound to the top level.
// Depends on kmsc_pkg and kruskal_mst_split_cost_core_macros.svh.
`include "kruskal_mst_split_cost_core_macros.svh"
module kmsc_checker import kmsc_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [SUM_W-1:0]     split_cost,
  input logic [SUM_W-1:0]     tree_cost,
  input logic [COST_IN_W-1:0] largest_edge,
  input logic [CNT_OUT_W-1:0] edges_used
);
  `KMSC_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `KMSC_NEXT(a_out_stable, out_valid && !out_ready, $stable(tree_cost) && $stable(split_cost))
  `KMSC_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `KMSC_IMPLIES(a_empty_forest, out_valid && edges_used == '0, tree_cost == '0 && largest_edge == '0)
  `KMSC_IMPLIES(a_split_le_tree, out_valid, split_cost <= tree_cost)
endmodule

bind kruskal_mst_split_cost_core kmsc_checker u_kmsc_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .split_cost(out_ch.split_cost), .tree_cost(out_ch.tree_cost),
  .largest_edge(out_ch.largest_edge), .edges_used(out_ch.edges_used)
);
